>>> design/postfix_stack_evaluator_assert.svh
// Assertion macros for the evaluator checker.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PSEV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("postfix evaluator check failed");

// Next-cycle implication, disabled while reset is high.
`define PSEV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("postfix evaluator check failed");

`endif

>>> design/psev_pkg.sv
// Shared types and codes for the postfix stack evaluator.
`timescale 1ns / 1ps
package psev_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [2:0]        status_t;
  typedef logic [1:0]        cmd_t;
  typedef logic [2:0]        op_t;

  localparam cmd_t CMD_PUSH = 2'd0;
  localparam cmd_t CMD_OP   = 2'd1;
  localparam cmd_t CMD_END  = 2'd2;
  localparam cmd_t CMD_NONE = 2'd3;

  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_MOD = 3'd4;
  localparam op_t OP_XOR = 3'd5;
  localparam op_t OP_AND = 3'd6;
  localparam op_t OP_OR  = 3'd7;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_FEW       = 3'd1;
  localparam status_t ST_DIVZ      = 3'd2;
  localparam status_t ST_MODZ      = 3'd3;
  localparam status_t ST_MALFORMED = 3'd4;
  localparam status_t ST_OVERFLOW  = 3'd5;
  localparam status_t ST_SKIPPED   = 3'd6;

  typedef struct packed {
    logic  go;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

endpackage

>>> design/psev_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module psev_div
  import psev_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(WORD_W);

  word_t            quo;
  word_t            rem;
  word_t            dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;

  logic [WORD_W:0] shifted;
  logic [WORD_W:0] trial;

  assign shifted = {rem, quo[WORD_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (req.go) begin
      run  <= 1'b1;
      done <= 1'b0;
    end else if (run) begin
      if (cnt == CNT_W'(WORD_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
      cnt <= '0;
    end else if (run) begin
      // A clear top bit of the trial difference means the divisor fits.
      if (!trial[WORD_W]) begin
        rem <= trial[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> design/postfix_stack_evaluator.sv
// Top level of the postfix expression evaluator with its operand stack.
//
//   channel   ports                                      handshake
//   request   cmd, number, operator_code                 start, busy
//   result    status, top_value, stack_depth,            valid (one-cycle strobe)
//             expression_done
//
// A request is taken when start is high and busy is low; push, end and logic or
// arithmetic operators other than divide and remainder report through the
// registered result after the execute state. Divide and remainder first run the
// shared divider over every quotient bit and report once it is done.
// Reset clears the stack pointer, the failed mark and the sequencer; the stack
// memory itself is not cleared. The result strobe cannot be stalled.
`timescale 1ns / 1ps
module postfix_stack_evaluator
  import psev_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       cmd,
  input  logic signed [WORD_W-1:0]         number,
  input  logic [2:0]                       operator_code,
  output logic                             valid,
  output logic [2:0]                       status,
  output logic signed [WORD_W-1:0]         top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0] stack_depth,
  output logic                             expression_done
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]    state, state_next;
  logic [DW-1:0] sp, sp_next;
  word_t         top, top_next;
  logic          failed, failed_next;

  cmd_t  cmd_q;
  word_t num_q;
  op_t   op_q;

  word_t         stack_mem [STACK_DEPTH];
  word_t         rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  word_t         mem_wd;

  logic          fin;
  status_t       res_status;
  word_t         res_top;
  logic [DW-1:0] res_depth;
  logic          res_done;

  div_req_t div_req;
  div_rsp_t div_rsp;

  word_t         top_cur;
  word_t         alu_r;
  word_t         div_r;
  logic [DW-1:0] sp_minus1;
  logic [DW-1:0] sp_minus2;
  logic          a_neg, b_neg;

  assign sp_minus1 = sp - DW'(1);
  assign sp_minus2 = sp - DW'(2);
  assign rd_addr   = sp_minus2[AW-1:0];
  assign top_cur   = (sp != '0) ? top : '0;

  // Left operand comes from memory, right operand is the cached top.
  assign a_neg = rd_data[WORD_W-1];
  assign b_neg = top[WORD_W-1];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    rd_data <= stack_mem[rd_addr];
  end

  always_comb begin
    unique case (op_q)
      OP_ADD:  alu_r = rd_data + top;
      OP_SUB:  alu_r = rd_data - top;
      OP_MUL:  alu_r = rd_data * top;
      OP_XOR:  alu_r = rd_data ^ top;
      OP_AND:  alu_r = rd_data & top;
      OP_OR:   alu_r = rd_data | top;
      OP_DIV:  alu_r = '0;
      OP_MOD:  alu_r = '0;
    endcase
  end

  // Signs are restored after the unsigned divide; the remainder follows the
  // dividend, the quotient is negative when the signs differ.
  always_comb begin
    if (op_q == OP_DIV) begin
      div_r = (a_neg ^ b_neg) ? (word_t'(0) - div_rsp.quotient) : div_rsp.quotient;
    end else begin
      div_r = a_neg ? (word_t'(0) - div_rsp.remainder) : div_rsp.remainder;
    end
  end

  always_comb begin
    state_next  = state;
    sp_next     = sp;
    top_next    = top;
    failed_next = failed;
    fin         = 1'b0;
    res_status  = ST_OK;
    res_top     = top_cur;
    res_depth   = sp;
    res_done    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = sp[AW-1:0];
    mem_wd      = num_q;
    div_req.go       = 1'b0;
    div_req.dividend = a_neg ? (word_t'(0) - rd_data) : rd_data;
    div_req.divisor  = b_neg ? (word_t'(0) - top) : top;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        fin = 1'b1;
        if (cmd_q == CMD_END) begin
          res_done    = 1'b1;
          res_depth   = '0;
          sp_next     = '0;
          failed_next = 1'b0;
          if (failed) begin
            res_status = ST_SKIPPED;
            res_top    = '0;
          end else begin
            res_status = (sp == DW'(1)) ? ST_OK : ST_MALFORMED;
          end
        end else if (cmd_q == CMD_NONE || failed) begin
          res_status = failed ? ST_SKIPPED : ST_OK;
        end else if (cmd_q == CMD_PUSH) begin
          if (sp == DW'(STACK_DEPTH)) begin
            res_status  = ST_OVERFLOW;
            failed_next = 1'b1;
          end else begin
            mem_we    = 1'b1;
            top_next  = num_q;
            sp_next   = sp + DW'(1);
            res_top   = num_q;
            res_depth = sp + DW'(1);
          end
        end else if (sp < DW'(2)) begin
          res_status  = ST_FEW;
          failed_next = 1'b1;
        end else if ((op_q == OP_DIV || op_q == OP_MOD) && top == '0) begin
          res_status  = (op_q == OP_DIV) ? ST_DIVZ : ST_MODZ;
          failed_next = 1'b1;
        end else if (op_q == OP_DIV || op_q == OP_MOD) begin
          fin        = 1'b0;
          div_req.go = 1'b1;
          state_next = S_DIV;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = sp_minus2[AW-1:0];
          mem_wd    = alu_r;
          top_next  = alu_r;
          sp_next   = sp_minus1;
          res_top   = alu_r;
          res_depth = sp_minus1;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fin       = 1'b1;
          mem_we    = 1'b1;
          mem_wa    = sp_minus2[AW-1:0];
          mem_wd    = div_r;
          top_next  = div_r;
          sp_next   = sp_minus1;
          res_top   = div_r;
          res_depth = sp_minus1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sp     <= '0;
      failed <= 1'b0;
      valid  <= 1'b0;
    end else begin
      state  <= state_next;
      sp     <= sp_next;
      failed <= failed_next;
      valid  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (state == S_IDLE && start) begin
      cmd_q <= cmd;
      num_q <= $unsigned(number);
      op_q  <= operator_code;
    end
    if (fin) begin
      status          <= res_status;
      top_value       <= $signed(res_top);
      stack_depth     <= res_depth;
      expression_done <= res_done;
    end
  end

  assign busy = (state != S_IDLE);

  psev_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

>>> design/psev_checker.sv
// Port-level checks for the postfix evaluator, bound to the top level.
`timescale 1ns / 1ps
`include "postfix_stack_evaluator_assert.svh"
module psev_checker
  import psev_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             valid,
  input logic [2:0]                       status,
  input logic signed [WORD_W-1:0]         top_value,
  input logic [$clog2(STACK_DEPTH+1)-1:0] stack_depth,
  input logic                             expression_done
);

  // The sequencer is busy, with no result strobe, in the cycle after a request is taken.
  `PSEV_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !valid)

  // The result strobe comes when the sequencer has already gone idle.
  `PSEV_ASSERT_IMP(a_valid_idle, clk, rst, valid, !busy)

  // An end request always leaves an empty stack.
  `PSEV_ASSERT_IMP(a_end_empty, clk, rst, valid && expression_done, stack_depth == '0)

  // A failed expression reports no answer at its end.
  `PSEV_ASSERT_IMP(a_end_skip_zero, clk, rst,
                   valid && expression_done && status == ST_SKIPPED, top_value == '0)

endmodule

bind postfix_stack_evaluator psev_checker #(.STACK_DEPTH(STACK_DEPTH)) u_psev_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench for the postfix stack evaluator.
`timescale 1ns / 1ps
module testbench
  import psev_pkg::*;
;

  localparam int STACK_WORDS = 64;
  localparam int DEPTH_W = $clog2(STACK_WORDS + 1);
  localparam int ITEM_GOAL = 650;
  localparam int STALL_LIMIT = 400;
  localparam int DRAIN_CYCLES = 40;

  localparam word_t WORD_MIN = 32'h8000_0000;
  localparam word_t WORD_MAX = 32'h7FFF_FFFF;
  localparam word_t MINUS_ONE = 32'hFFFF_FFFF;

  typedef enum int {DEFECT_NONE, DEFECT_MISSING_OP, DEFECT_EARLY_OP, DEFECT_IDLE_CMD} defect_t;

  typedef struct {
    status_t            status;
    word_t              top;
    logic [DEPTH_W-1:0] depth;
    logic               done;
  } answer_t;

  class postfix_scoreboard;
    word_t       operand_words [STACK_WORDS];
    int unsigned depth;
    bit          failed;
    answer_t     pending_answers[$];
    int          errors;
    int          results_checked;
    int          expressions_closed;
    int          error_results;
    int          skipped_results;

    function word_t top_word();
      return (depth == 0) ? '0 : operand_words[depth-1];
    endfunction

    // Works out the answer for one accepted request and queues it. Returns 1
    // when the request did real work, i.e. was neither idle nor skipped.
    function bit note_request(cmd_t req_cmd, word_t req_number, op_t req_op);
      answer_t ans;
      word_t   lhs;
      word_t   rhs;
      word_t   value;
      longint  wide;
      ans.status = ST_OK;
      ans.done   = 1'b0;
      value      = '0;
      if (req_cmd == CMD_END) begin
        if (failed) begin
          ans.status = ST_SKIPPED;
          ans.top    = '0;
        end else begin
          ans.status = (depth == 1) ? ST_OK : ST_MALFORMED;
          ans.top    = top_word();
        end
        depth    = 0;
        failed   = 1'b0;
        ans.done = 1'b1;
      end else if (req_cmd == CMD_NONE || failed) begin
        ans.status = failed ? ST_SKIPPED : ST_OK;
        ans.top    = top_word();
      end else if (req_cmd == CMD_PUSH) begin
        if (depth >= STACK_WORDS) begin
          ans.status = ST_OVERFLOW;
          failed     = 1'b1;
        end else begin
          operand_words[depth] = req_number;
          depth++;
        end
        ans.top = top_word();
      end else begin
        if (depth < 2) begin
          ans.status = ST_FEW;
        end else begin
          lhs = operand_words[depth-2];
          rhs = operand_words[depth-1];
          case (req_op)
            OP_ADD: value = lhs + rhs;
            OP_SUB: value = lhs - rhs;
            OP_MUL: value = lhs * rhs;
            OP_DIV: begin
              if (rhs == '0) begin
                ans.status = ST_DIVZ;
              end else begin
                // Wide arithmetic keeps the minimum over minus one case exact.
                wide  = longint'($signed(lhs)) / longint'($signed(rhs));
                value = wide[31:0];
              end
            end
            OP_MOD: begin
              if (rhs == '0) begin
                ans.status = ST_MODZ;
              end else begin
                wide  = longint'($signed(lhs)) % longint'($signed(rhs));
                value = wide[31:0];
              end
            end
            OP_XOR: value = lhs ^ rhs;
            OP_AND: value = lhs & rhs;
            default: value = lhs | rhs;
          endcase
          if (ans.status == ST_OK) begin
            depth--;
            operand_words[depth-1] = value;
          end
        end
        if (ans.status != ST_OK) failed = 1'b1;
        ans.top = top_word();
      end
      ans.depth = DEPTH_W'(depth);
      pending_answers.push_back(ans);
      return (req_cmd != CMD_NONE) && (ans.status != ST_SKIPPED);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task check_result(status_t got_status, word_t got_top, logic [DEPTH_W-1:0] got_depth,
                      logic got_done);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, status %0d", got_status));
        return;
      end
      want = pending_answers.pop_front();
      results_checked++;
      if (want.done) expressions_closed++;
      if (want.status == ST_SKIPPED) skipped_results++;
      else if (want.status != ST_OK) error_results++;
      if (got_status !== want.status || got_top !== want.top || got_depth !== want.depth ||
          got_done !== want.done)
        report_mismatch($sformatf(
          "result %0d: got status %0d top %0d depth %0d done %0b, want %0d %0d %0d %0b",
          results_checked, got_status, $signed(got_top), got_depth, got_done,
          want.status, $signed(want.top), want.depth, want.done));
    endtask

    function int outstanding();
      return pending_answers.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  cmd_t                    cmd = CMD_PUSH;
  logic signed [31:0]      number = '0;
  op_t                     operator_code = OP_ADD;
  logic                    valid;
  status_t                 status;
  logic signed [31:0]      top_value;
  logic [DEPTH_W-1:0]      stack_depth;
  logic                    expression_done;

  postfix_scoreboard board = new();
  int burst_left = 0;
  int useful_requests = 0;
  int sent_requests = 0;
  int stall_cycles = 0;

  postfix_stack_evaluator #(
    .STACK_DEPTH(STACK_WORDS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .number(number),
    .operator_code(operator_code),
    .valid(valid),
    .status(status),
    .top_value(top_value),
    .stack_depth(stack_depth),
    .expression_done(expression_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && valid) board.check_result(status, top_value, stack_depth, expression_done);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Requests go out in bursts; between bursts start drops for a random gap.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  task automatic send_request(cmd_t req_cmd, word_t req_number, op_t req_op);
    pace_sender();
    start         <= 1'b1;
    cmd           <= req_cmd;
    number        <= req_number;
    operator_code <= req_op;
    do @(posedge clk); while (busy);
    sent_requests++;
    if (board.note_request(req_cmd, req_number, req_op)) useful_requests++;
  endtask

  function automatic op_t random_op();
    return op_t'($urandom_range(0, 7));
  endfunction

  function automatic word_t random_number();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 32'd1;
          2: return MINUS_ONE;
          3: return WORD_MIN;
          default: return WORD_MAX;
        endcase
      end
      1, 2, 3, 4, 5: return word_t'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(word_t value);
    send_request(CMD_PUSH, value, random_op());
  endtask

  task automatic apply_operator(op_t op);
    send_request(CMD_OP, $urandom, op);
  endtask

  task automatic close_expression();
    send_request(CMD_END, $urandom, random_op());
  endtask

  task automatic run_directed();
    // Operator on an empty stack, then everything up to the end is skipped.
    apply_operator(OP_ADD);
    push_word(32'd5);
    close_expression();
    // End with nothing on the stack.
    close_expression();
    // Minimum over minus one wraps; its remainder is zero.
    push_word(WORD_MIN);
    push_word(MINUS_ONE);
    apply_operator(OP_DIV);
    push_word(MINUS_ONE);
    apply_operator(OP_MOD);
    push_word(WORD_MAX);
    apply_operator(OP_SUB);
    send_request(CMD_NONE, $urandom, random_op());
    close_expression();
    push_word(-32'sd7);
    push_word(32'd2);
    apply_operator(OP_MOD);
    push_word(32'd3);
    apply_operator(OP_MUL);
    push_word(32'hF0F0_F0F0);
    apply_operator(OP_XOR);
    push_word(32'h0FF0_0FF0);
    apply_operator(OP_AND);
    push_word(32'h8000_0001);
    apply_operator(OP_OR);
    push_word('0);
    apply_operator(OP_DIV);
    close_expression();
    push_word(32'd1);
    push_word('0);
    apply_operator(OP_MOD);
    close_expression();
    // Two entries left at the end.
    push_word(32'd1);
    push_word(32'd2);
    close_expression();
  endtask

  task automatic send_deep(int count);
    for (int i = 0; i < count; i++) push_word(random_number());
    if ($urandom_range(0, 1)) apply_operator(random_op());
    close_expression();
  endtask

  task automatic send_noise(int count);
    for (int i = 0; i < count; i++)
      send_request(cmd_t'($urandom_range(0, 3)), $urandom, random_op());
    close_expression();
  endtask

  // Builds a postfix expression over the given number of operands; a defect
  // can break it so the error paths are reached from realistic states.
  task automatic send_expression(int operands, defect_t defect);
    int pushes_left;
    int height;
    int idle_at;
    int step;
    pushes_left = operands;
    height = 0;
    step = 0;
    idle_at = $urandom_range(0, 2 * operands);
    if (defect == DEFECT_EARLY_OP) apply_operator(random_op());
    while (pushes_left > 0 || height > 1) begin
      if (defect == DEFECT_IDLE_CMD && step == idle_at)
        send_request(CMD_NONE, $urandom, random_op());
      if (height >= 2 && (pushes_left == 0 || $urandom_range(0, 1))) begin
        if (defect == DEFECT_MISSING_OP && pushes_left == 0 && height == 2) break;
        apply_operator(random_op());
        height--;
      end else begin
        push_word(random_number());
        pushes_left--;
        height++;
      end
      step++;
    end
    close_expression();
  endtask

  initial begin
    int kind;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    send_deep(STACK_WORDS + 1);
    while (sent_requests < ITEM_GOAL) begin
      kind = $urandom_range(0, 29);
      if (kind == 0) send_deep($urandom_range(STACK_WORDS - 2, STACK_WORDS + 2));
      else if (kind < 4) send_noise($urandom_range(1, 6));
      else if (kind < 10) send_expression($urandom_range(0, 8), defect_t'($urandom_range(1, 3)));
      else send_expression($urandom_range(1, 10), DEFECT_NONE);
    end
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d doing real work) over %0d expressions, %0d compared.",
             sent_requests, useful_requests, board.expressions_closed, board.results_checked);
    $display("Results flagged an error %0d times and reported a skip %0d times.",
             board.error_results, board.skipped_results);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> postfix_stack_evaluator.f
+incdir+design
design/psev_pkg.sv
design/psev_div.sv
design/postfix_stack_evaluator.sv
design/psev_checker.sv
verif/testbench.sv
